### hdl/lcg_rvu_pkg.sv
// Shared types, codes and constants of the LCG random variate unit.
`default_nettype none
package lcg_rvu_pkg;

	localparam int SEED_W   = 32;
	localparam int VAR_W    = 32;
	localparam int TRIAL_W  = 16;
	localparam int PROB_W   = 33;
	localparam int CCOUNT_W = 3;
	localparam int CIDX_W   = 3;
	localparam int SUM_W    = 36;	// six 33-bit probabilities summed
	localparam int CFG_W    = 33;

	localparam int unsigned MAX_CLASSES_DEF = 6;
	localparam int unsigned MAX_TRIALS_DEF  = 65535;

	localparam logic [SEED_W-1:0]   LCG_MUL      = 32'd69069;
	localparam logic [SEED_W-1:0]   LCG_INC      = 32'd1;
	localparam logic [SEED_W-1:0]   SEED_RESET   = 32'd1;
	localparam logic [CCOUNT_W-1:0] CCOUNT_RESET = 3'd1;
	localparam logic [PROB_W-1:0]   PROB0_RESET  = 33'h1_0000_0000;

	// register indexes
	localparam logic [CIDX_W-1:0] CFG_SEED        = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_CLASS_COUNT = 3'd1;
	localparam int                CFG_PROB0       = 2;

	typedef enum logic [1:0] {
		CMD_UNIFORM  = 2'd0,
		CMD_BINOMIAL = 2'd1,
		CMD_CLASS    = 2'd2
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISP,
		ST_SPAN,
		ST_MUL,
		ST_ADD,
		ST_BIN,
		ST_BCHK,
		ST_CADV,
		ST_CWALK,
		ST_DONE
	} st_t;

	typedef struct packed {
		logic load;
		logic adv;
		logic span;
		logic mul;
		logic add_lo;
		logic bin_draw;
		logic cls_step;
		logic out_load;
	} ctrl_t;

	typedef struct packed {
		cmd_t cmd;
		logic rem_zero;
		logic rem_last;
		logic cls_go;
		logic out_free;
	} stat_t;

endpackage
`default_nettype wire

### hdl/lcg_random_variate_unit.sv
// Top level of the LCG random variate unit: controller, datapath and checks.
// Each beat is dispatched on its command: uniform runs the span, multiply and add steps,
// binomial loops over the trials, class pick walks the classes, other codes finish directly.
// One request at a time: a new beat is taken only once the result is registered.
// The binomial loop draws one seed per cycle, so its rate is set by the trial count.
// arst_n clears control state; the seed resets to 1, class_count to 1, class 0 holds all mass.
`default_nettype none
module lcg_random_variate_unit #(
	parameter int unsigned MAX_CLASSES = lcg_rvu_pkg::MAX_CLASSES_DEF,
	parameter int unsigned MAX_TRIALS  = lcg_rvu_pkg::MAX_TRIALS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// configuration write port
	input  wire logic                                 cfg_write,
	input  wire logic [lcg_rvu_pkg::CIDX_W-1:0]       cfg_index,
	input  wire logic [lcg_rvu_pkg::CFG_W-1:0]        cfg_data,
	// request beats
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [1:0]                           cmd,
	input  wire logic signed [lcg_rvu_pkg::VAR_W-1:0] range_low,
	input  wire logic signed [lcg_rvu_pkg::VAR_W-1:0] range_high,
	input  wire logic [lcg_rvu_pkg::TRIAL_W-1:0]      trial_count,
	input  wire logic [lcg_rvu_pkg::PROB_W-1:0]       success_threshold,
	// result beats
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [lcg_rvu_pkg::VAR_W-1:0]      variate,
	output logic [lcg_rvu_pkg::SEED_W-1:0]            seed_after
);
	import lcg_rvu_pkg::*;

	ctrl_t ctl;
	stat_t stat;
	st_t   st;

	// sequencer: walks the mode's steps, one seed draw per cycle at most
	lcg_rvu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.ctl      (ctl),
		.st       (st)
	);

	// datapath: LCG step, 32x32 span multiply, trial counter, class walk
	lcg_rvu_dp #(
		.MAX_CLASSES (MAX_CLASSES),
		.MAX_TRIALS  (MAX_TRIALS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_write         (cfg_write),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.cmd               (cmd),
		.range_low         (range_low),
		.range_high        (range_high),
		.trial_count       (trial_count),
		.success_threshold (success_threshold),
		.ctl               (ctl),
		.stat              (stat),
		.out_stall         (out_stall),
		.out_valid         (out_valid),
		.variate           (variate),
		.seed_after        (seed_after)
	);

	// an accepted beat always leaves the sequencer busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (st != ST_IDLE))
		else $error("sequencer idle after accepting a beat");

	// a result load always raises the output valid
	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |=> out_valid)
		else $error("result load lost");

	// results only appear out of the finishing step
	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(st) == ST_DONE))
		else $error("result raised outside the finishing step");

endmodule
`default_nettype wire

### hdl/lcg_rvu_ctrl.sv
// Sequencing state machine of the LCG random variate unit.
`default_nettype none
module lcg_rvu_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire lcg_rvu_pkg::stat_t  stat,
	output lcg_rvu_pkg::ctrl_t       ctl,
	output lcg_rvu_pkg::st_t         st
);
	import lcg_rvu_pkg::*;

	st_t st_q;
	st_t st_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_nx;
		end
	end

	always_comb begin
		st_nx = st_q;
		case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					st_nx = ST_DISP;
				end
			end
			// mode dispatch once the beat's command is latched
			ST_DISP: begin
				case (stat.cmd)
					CMD_UNIFORM:  st_nx = ST_SPAN;
					CMD_BINOMIAL: st_nx = ST_BIN;
					CMD_CLASS:    st_nx = ST_CADV;
					default:      st_nx = ST_DONE;
				endcase
			end
			ST_SPAN:  st_nx = ST_MUL;
			ST_MUL:   st_nx = ST_ADD;
			ST_ADD:   st_nx = ST_DONE;
			ST_BIN: begin
				if (stat.rem_zero) begin
					st_nx = ST_DONE;
				end else if (stat.rem_last) begin
					st_nx = ST_BCHK;
				end
			end
			ST_BCHK:  st_nx = ST_DONE;
			ST_CADV:  st_nx = ST_CWALK;
			ST_CWALK: begin
				if (!stat.cls_go) begin
					st_nx = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					st_nx = ST_IDLE;
				end
			end
			default:  st_nx = ST_IDLE;
		endcase
	end

	assign st = st_q;

	always_comb begin
		ctl      = '0;
		in_stall = 1'b1;
		case (st_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				ctl.load = in_valid;
			end
			ST_SPAN: begin
				ctl.adv  = 1'b1;
				ctl.span = 1'b1;
			end
			ST_MUL:  ctl.mul = 1'b1;
			ST_ADD:  ctl.add_lo = 1'b1;
			ST_BIN: begin
				ctl.adv      = !stat.rem_zero;
				ctl.bin_draw = !stat.rem_zero;
			end
			ST_BCHK:  ctl = '0;
			ST_CADV:  ctl.adv = 1'b1;
			ST_CWALK: ctl.cls_step = stat.cls_go;
			ST_DONE:  ctl.out_load = stat.out_free;
			default:  ctl = '0;
		endcase
	end

endmodule
`default_nettype wire

### hdl/lcg_rvu_dp.sv
// Datapath of the LCG random variate unit: seed, config store, draw arithmetic, result register.
`default_nettype none
module lcg_rvu_dp #(
	parameter int unsigned MAX_CLASSES = lcg_rvu_pkg::MAX_CLASSES_DEF,
	parameter int unsigned MAX_TRIALS  = lcg_rvu_pkg::MAX_TRIALS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_write,
	input  wire logic [lcg_rvu_pkg::CIDX_W-1:0]         cfg_index,
	input  wire logic [lcg_rvu_pkg::CFG_W-1:0]          cfg_data,
	input  wire logic [1:0]                             cmd,
	input  wire logic signed [lcg_rvu_pkg::VAR_W-1:0]   range_low,
	input  wire logic signed [lcg_rvu_pkg::VAR_W-1:0]   range_high,
	input  wire logic [lcg_rvu_pkg::TRIAL_W-1:0]        trial_count,
	input  wire logic [lcg_rvu_pkg::PROB_W-1:0]         success_threshold,
	input  wire lcg_rvu_pkg::ctrl_t                     ctl,
	output lcg_rvu_pkg::stat_t                          stat,
	input  wire logic                                   out_stall,
	output logic                                        out_valid,
	output logic signed [lcg_rvu_pkg::VAR_W-1:0]        variate,
	output logic [lcg_rvu_pkg::SEED_W-1:0]              seed_after
);
	import lcg_rvu_pkg::*;

	localparam int CLS_W = $clog2(MAX_CLASSES);

	// configuration and seed
	logic [SEED_W-1:0]   seed_q;
	logic [CCOUNT_W-1:0] class_count_q;
	logic [PROB_W-1:0]   prob_q [MAX_CLASSES];

	// per-request working registers
	cmd_t                cmd_q;
	logic                chk_q;
	logic                out_valid_q;
	logic [VAR_W-1:0]    lo_q;
	logic [VAR_W-1:0]    hi_q;
	logic [SEED_W:0]     span_q;
	logic [SEED_W-1:0]   prod_hi_q;
	logic [VAR_W-1:0]    res_q;
	logic [TRIAL_W-1:0]  rem_q;
	logic [PROB_W-1:0]   thr_q;
	logic [CLS_W-1:0]    c_q;
	logic [SUM_W-1:0]    sum_q;
	logic [VAR_W-1:0]    variate_q;
	logic [SEED_W-1:0]   seed_after_q;

	logic [SEED_W-1:0]   seed_nx;
	logic [2*SEED_W-1:0] prod;
	logic [SEED_W-1:0]   mul_hi;
	logic [TRIAL_W-1:0]  n_clamp;
	logic                swap;
	logic [CCOUNT_W-1:0] kc;
	logic [CLS_W-1:0]    c_nx;
	logic [PROB_W-1:0]   prob_nx;
	logic                hit;
	logic [VAR_W-1:0]    var_sel;

	assign seed_nx = SEED_W'(seed_q * LCG_MUL) + LCG_INC;
	assign prod    = (2*SEED_W)'(seed_q) * (2*SEED_W)'(span_q[SEED_W-1:0]);
	// a full 2^32 span returns the seed itself
	assign mul_hi  = span_q[SEED_W] ? seed_q : prod[2*SEED_W-1:SEED_W];
	assign n_clamp = (32'(trial_count) > MAX_TRIALS) ? TRIAL_W'(MAX_TRIALS) : trial_count;
	assign swap    = range_high < range_low;
	assign hit     = chk_q && ({1'b0, seed_q} < thr_q);

	always_comb begin
		if (class_count_q == '0) begin
			kc = CCOUNT_W'(1);
		end else if (32'(class_count_q) > MAX_CLASSES) begin
			kc = CCOUNT_W'(MAX_CLASSES);
		end else begin
			kc = class_count_q;
		end
	end

	assign c_nx    = c_q + 1'b1;
	assign prob_nx = (32'(c_nx) < MAX_CLASSES) ? prob_q[c_nx] : '0;

	assign stat.cmd      = cmd_q;
	assign stat.rem_zero = rem_q == '0;
	assign stat.rem_last = rem_q == TRIAL_W'(1);
	assign stat.cls_go   = ({(SUM_W-SEED_W)'(0), seed_q} > sum_q)
		&& ((4'(c_q) + 4'd1) < 4'(kc));
	assign stat.out_free = !out_valid_q || !out_stall;

	// seed and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q        <= SEED_RESET;
			class_count_q <= CCOUNT_RESET;
			for (int i = 0; i < MAX_CLASSES; i++) begin
				prob_q[i] <= (i == 0) ? PROB0_RESET : '0;
			end
		end else begin
			if (cfg_write && cfg_index == CFG_SEED) begin
				seed_q <= cfg_data[SEED_W-1:0];
			end else if (ctl.adv) begin
				seed_q <= seed_nx;
			end
			if (cfg_write && cfg_index == CFG_CLASS_COUNT) begin
				class_count_q <= cfg_data[CCOUNT_W-1:0];
			end
			for (int i = 0; i < MAX_CLASSES; i++) begin
				if (cfg_write && cfg_index == CIDX_W'(CFG_PROB0 + i)) begin
					prob_q[i] <= cfg_data[PROB_W-1:0];
				end
			end
		end
	end

	// control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q       <= CMD_UNIFORM;
			chk_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.load) begin
				cmd_q <= cmd_t'(cmd);
			end
			chk_q <= ctl.bin_draw;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		case (cmd_q)
			CMD_UNIFORM:  var_sel = res_q;
			CMD_BINOMIAL: var_sel = res_q;
			CMD_CLASS:    var_sel = VAR_W'(c_q);
			default:      var_sel = '0;
		endcase
	end

	// payload
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			lo_q  <= swap ? range_high : range_low;
			hi_q  <= swap ? range_low : range_high;
			rem_q <= n_clamp;
			thr_q <= success_threshold;
			c_q   <= '0;
			sum_q <= SUM_W'(prob_q[0]);
			res_q <= '0;
		end else begin
			if (ctl.span) begin
				span_q <= {hi_q[VAR_W-1], hi_q} - {lo_q[VAR_W-1], lo_q} + (SEED_W+1)'(1);
			end
			if (ctl.mul) begin
				prod_hi_q <= mul_hi;
			end
			if (ctl.add_lo) begin
				res_q <= lo_q + prod_hi_q;
			end else if (hit) begin
				res_q <= res_q + VAR_W'(1);
			end
			if (ctl.bin_draw) begin
				rem_q <= rem_q - TRIAL_W'(1);
			end
			if (ctl.cls_step) begin
				c_q   <= c_nx;
				sum_q <= sum_q + SUM_W'(prob_nx);
			end
		end
		if (ctl.out_load) begin
			variate_q    <= var_sel;
			seed_after_q <= seed_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign variate    = variate_q;
	assign seed_after = seed_after_q;

endmodule
`default_nettype wire
